// ===== rtl/core/fcts_pkg.sv =====
// Package for the floor cast texel shader: payload structs, constants, sine table entries.
// No dependencies.
package fcts_pkg;

  localparam int TexDim = 64;
  localparam int SquareLen = 64;
  localparam int TrigEntries = 1024;
  localparam int TrigBits = 10;
  localparam int StoreDepth = 4096;
  localparam int StoreBits = 12;
  localparam int ModBits = 14;
  localparam int TexBits = 6;
  localparam logic [23:0] DistMax = 24'hFFFFFF;

  localparam logic ActLoad = 1'b0;
  localparam logic ActShade = 1'b1;

  localparam logic [2:0] RegTexWidth = 3'd0;
  localparam logic [2:0] RegTexHeight = 3'd1;
  localparam logic [2:0] RegScreenHeight = 3'd2;
  localparam logic [2:0] RegProjPlaneDist = 3'd3;
  localparam logic [2:0] RegVerticalOffset = 3'd4;

  typedef struct packed {
    logic        action;
    logic [11:0] texel_addr;
    logic [31:0] texel_value;
    logic [15:0] ray_angle;
    logic [15:0] view_angle;
    logic [23:0] player_px;
    logic [23:0] player_py;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic [31:0] out_color;
    logic        draw;
  } out_item_t;

  // Classified job handed from front to back.
  // A texel load carries its value in ray/beta and its address in col.
  typedef struct packed {
    logic        load;
    logic        below;
    logic [12:0] r;
    logic [15:0] ray;
    logic [15:0] beta;
    logic [23:0] px;
    logic [23:0] py;
    logic [11:0] row;
    logic [11:0] col;
  } job_t;

  // Sine in Q1.15, folded quadrant and Taylor series in Q2.30.
  function automatic logic signed [15:0] sine_entry(input int k);
    logic [63:0] x, x2, term, sum, q;
    logic neg;
    begin
      x = (64'(k) * 64'd6746518852) / 64'(TrigEntries);
      neg = 1'b0;
      if (x >= 64'd3373259426) begin
        x = x - 64'd3373259426;
        neg = 1'b1;
      end
      if (x > 64'd1686629713) x = 64'd3373259426 - x;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 3; n <= 13; n += 2) begin
        term = ((term * x2) >> 30) / 64'((n - 1) * n);
        if ((((n - 1) / 2) & 1) != 0) sum = sum - term;
        else sum = sum + term;
      end
      q = (sum + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      sine_entry = neg ? -16'(q) : 16'(q);
    end
  endfunction

endpackage

// ===== rtl/core/fcts_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
module fcts_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/fcts_front.sv =====
// Front end: accepts items, classifies shade items against the horizon, tags texel loads.
// Depends on fcts_pkg.
module fcts_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fcts_pkg::in_item_t in_item,
  input  logic [11:0]       screen_height,
  input  logic signed [11:0] vertical_offset,
  output logic              job_valid,
  output fcts_pkg::job_t    job
);
  logic signed [13:0] horizon;
  logic signed [13:0] r_full;

  always_comb begin
    horizon = 14'($signed({1'b0, screen_height[11:1]})) + 14'(vertical_offset);
    r_full = 14'($signed({1'b0, in_item.pixel_row})) - horizon;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= start;
    end
    job.load <= in_item.action == fcts_pkg::ActLoad;
    job.below <= in_item.action == fcts_pkg::ActShade && r_full > 14'sd0;
    job.r <= r_full[12:0];
    if (in_item.action == fcts_pkg::ActLoad) begin
      job.ray <= in_item.texel_value[31:16];
      job.beta <= in_item.texel_value[15:0];
      job.col <= in_item.texel_addr;
    end else begin
      job.ray <= in_item.ray_angle;
      job.beta <= in_item.ray_angle - in_item.view_angle;
      job.col <= in_item.pixel_col;
    end
    job.px <= in_item.player_px;
    job.py <= in_item.player_py;
    job.row <= in_item.pixel_row;
  end
endmodule

// ===== rtl/core/fcts_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Depends on fcts_pkg for the job tag carried alongside.
module fcts_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [38:0]    num,
  input  logic [23:0]    den,
  input  fcts_pkg::job_t in_tag,
  input  logic [15:0]    in_aux,
  output logic           out_valid,
  output logic [38:0]    quo,
  output fcts_pkg::job_t out_tag,
  output logic [15:0]    out_aux
);
  localparam int N = 39;
  logic           v   [N+1];
  logic [38:0]    q   [N+1];
  logic [24:0]    rem [N+1];
  logic [23:0]    d   [N+1];
  fcts_pkg::job_t tg  [N+1];
  logic [15:0]    ax  [N+1];

  always_comb begin
    v[0] = in_valid;
    q[0] = num;
    rem[0] = '0;
    d[0] = den;
    tg[0] = in_tag;
    ax[0] = in_aux;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [25:0] sh;
    logic [25:0] df;
    always_comb begin
      sh = {rem[i], q[i][38]};
      df = sh - {2'b0, d[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      if (!df[25]) begin
        rem[i+1] <= df[24:0];
        q[i+1] <= {q[i][37:0], 1'b1};
      end else begin
        rem[i+1] <= sh[24:0];
        q[i+1] <= {q[i][37:0], 1'b0};
      end
      d[i+1] <= d[i];
      tg[i+1] <= tg[i];
      ax[i+1] <= ax[i];
    end
  end

  assign out_valid = v[N];
  assign quo = q[N];
  assign out_tag = tg[N];
  assign out_aux = ax[N];
endmodule

// ===== rtl/core/fcts_back.sv =====
// Back end: distance divisions, floor point, texel address, texel store and result register.
// Depends on fcts_pkg, fcts_div and fcts_ram.
module fcts_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  fcts_pkg::job_t    job,
  input  logic [23:0]       proj_plane_dist,
  input  logic [6:0]        tex_width,
  input  logic [6:0]        tex_height,
  output logic              done,
  output fcts_pkg::out_item_t result
);
  // Quarter-wave sine tables, quadrants 0/2 and 1/3
  logic signed [15:0] sin_lo [256];
  logic signed [15:0] sin_hi [256];
  for (genvar j = 0; j < 256; j++) begin : g_sine
    localparam logic signed [15:0] Lo = fcts_pkg::sine_entry(j);
    localparam logic signed [15:0] Hi = fcts_pkg::sine_entry(j + 256);
    assign sin_lo[j] = Lo;
    assign sin_hi[j] = Hi;
  end

  function automatic logic signed [15:0] sine_lut(input logic [15:0] a);
    logic [7:0] j;
    logic signed [15:0] m;
    begin
      j = a[13:6];
      m = a[14] ? sin_hi[j] : sin_lo[j];
      sine_lut = a[15] ? -m : m;
    end
  endfunction

  // Stage A: first division straight = SquareLen/2 * ppd / r
  logic [38:0] num1;
  logic [23:0] den1;
  logic [15:0] cb_a;
  always_comb begin
    num1 = job.below ? 39'(proj_plane_dist) << 5 : '0;
    den1 = job.below ? 24'(job.r) : 24'd1;
    cb_a = sine_lut(job.beta + 16'd16384);
  end

  logic           d1_v;
  logic [38:0]    d1_q;
  fcts_pkg::job_t d1_t;
  logic [15:0]    d1_cb;
  fcts_div u_div1 (
    .clk(clk), .rst(rst), .in_valid(job_valid), .num(num1), .den(den1),
    .in_tag(job), .in_aux(cb_a), .out_valid(d1_v), .quo(d1_q),
    .out_tag(d1_t), .out_aux(d1_cb));

  // Second division dist = straight * 32768 / |cb|
  logic [23:0] straight;
  logic [15:0] mag;
  logic [38:0] num2;
  logic [23:0] den2;
  always_comb begin
    straight = (d1_q > 39'(fcts_pkg::DistMax)) ? fcts_pkg::DistMax : d1_q[23:0];
    mag = d1_cb[15] ? -d1_cb : d1_cb;
    num2 = {straight, 15'b0};
    den2 = (mag == '0) ? 24'd1 : 24'(mag);
  end

  logic           d2_v;
  logic [38:0]    d2_q;
  fcts_pkg::job_t d2_t;
  logic [15:0]    d2_cb;
  fcts_div u_div2 (
    .clk(clk), .rst(rst), .in_valid(d1_v), .num(num2), .den(den2),
    .in_tag(d1_t), .in_aux(d1_cb), .out_valid(d2_v), .quo(d2_q),
    .out_tag(d2_t), .out_aux(d2_cb));

  // Stage B: signed dist and trig of ray
  logic signed [24:0] dist_b;
  logic signed [15:0] sr_b, cr_b;
  fcts_pkg::job_t     t_b;
  logic               v_b;
  logic [23:0]        mdist;
  always_comb begin
    if (d2_cb == '0 || d2_q > 39'(fcts_pkg::DistMax)) mdist = fcts_pkg::DistMax;
    else mdist = d2_q[23:0];
  end
  always_ff @(posedge clk) begin
    if (rst) v_b <= 1'b0;
    else v_b <= d2_v;
    dist_b <= d2_cb[15] ? -$signed({1'b0, mdist}) : $signed({1'b0, mdist});
    sr_b <= sine_lut(d2_t.ray);
    cr_b <= sine_lut(d2_t.ray + 16'd16384);
    t_b <= d2_t;
  end

  // Stage C: products
  logic signed [40:0] px_c, py_c;
  fcts_pkg::job_t     t_c;
  logic               v_c;
  always_ff @(posedge clk) begin
    if (rst) v_c <= 1'b0;
    else v_c <= v_b;
    px_c <= 41'(sr_b) * 41'(dist_b);
    py_c <= 41'(cr_b) * 41'(dist_b);
    t_c <= t_b;
  end

  // Stage D: floor point modulo cell (arithmetic shift is floor division)
  logic [13:0] fx_d, fy_d;
  fcts_pkg::job_t t_d;
  logic v_d;
  logic [25:0] sx, sy;
  always_comb begin
    sx = 26'(px_c >>> 15);
    sy = 26'(py_c >>> 15);
  end
  always_ff @(posedge clk) begin
    if (rst) v_d <= 1'b0;
    else v_d <= v_c;
    fx_d <= t_c.py[13:0] + sx[13:0];
    fy_d <= t_c.px[13:0] + sy[13:0];
    t_d <= t_c;
  end

  // Stage E: texel address; loads write the store at the same stage, in order
  logic [20:0] cx, cy;
  logic [11:0] raddr;
  fcts_pkg::job_t t_e;
  logic v_e;
  always_comb begin
    cx = 21'(tex_width) * 21'(fx_d);
    cy = 21'(tex_height) * 21'(fy_d);
  end
  always_ff @(posedge clk) begin
    if (rst) v_e <= 1'b0;
    else v_e <= v_d;
    t_e <= t_d;
  end
  assign raddr = 12'({cy[19:14], 6'b0} + 12'(cx[20:14]));

  logic [31:0] rdata;
  fcts_ram #(.Width(32), .Depth(fcts_pkg::StoreDepth)) u_store (
    .clk(clk), .we(v_d && t_d.load), .waddr(t_d.col), .wdata({t_d.ray, t_d.beta}),
    .raddr(raddr), .rdata(rdata));

  logic [31:0] color;
  assign color = t_e.below ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v_e && !t_e.load;
    result.out_col <= t_e.col;
    result.out_row <= t_e.row;
    result.out_color <= color;
    result.draw <= color != '0;
  end

`ifndef SYNTHESIS
  a_draw_color: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.draw == (result.out_color != '0))) else $error("draw mismatch");
  a_above_black: assert property (@(posedge clk) disable iff (rst)
    v_e && !t_e.below |=> result.out_color == '0) else $error("above horizon color");
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    v_d |=> v_e) else $error("pipe lost item");
`endif
endmodule

// ===== rtl/core/floor_cast_texel_shader.sv =====
// Floor cast texel shader: one item per cycle; each result passes the front register, two
// 39-stage pipelined dividers, stages B to E and the result register; busy never rises.
// Synchronous active-high reset clears control; texel store is undefined until loaded.
// Depends on fcts_pkg, fcts_front, fcts_back.
module floor_cast_texel_shader (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fcts_pkg::in_item_t  in_item,
  output logic                strobe,
  output fcts_pkg::out_item_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [6:0]  tex_width, tex_height;
  logic [11:0] screen_height;
  logic [23:0] proj_plane_dist;
  logic signed [11:0] vertical_offset;

  assign pready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width <= 7'd64;
      tex_height <= 7'd64;
      screen_height <= 12'd1024;
      proj_plane_dist <= 24'd221696;
      vertical_offset <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        fcts_pkg::RegTexWidth: tex_width <= pwdata[6:0];
        fcts_pkg::RegTexHeight: tex_height <= pwdata[6:0];
        fcts_pkg::RegScreenHeight: screen_height <= pwdata[11:0];
        fcts_pkg::RegProjPlaneDist: proj_plane_dist <= pwdata[23:0];
        fcts_pkg::RegVerticalOffset: vertical_offset <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      fcts_pkg::RegTexWidth: prdata = 32'(tex_width);
      fcts_pkg::RegTexHeight: prdata = 32'(tex_height);
      fcts_pkg::RegScreenHeight: prdata = 32'(screen_height);
      fcts_pkg::RegProjPlaneDist: prdata = 32'(proj_plane_dist);
      fcts_pkg::RegVerticalOffset: prdata = 32'(vertical_offset);
      default: prdata = '0;
    endcase
  end

  logic job_valid;
  fcts_pkg::job_t job;

  fcts_front u_front (
    .clk(clk), .rst(rst), .start(start && !busy), .in_item(in_item),
    .screen_height(screen_height), .vertical_offset(vertical_offset),
    .job_valid(job_valid), .job(job));

  fcts_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job),
    .proj_plane_dist(proj_plane_dist), .tex_width(tex_width), .tex_height(tex_height),
    .done(strobe), .result(result));
endmodule

// ===== tb/floor_cast_texel_shader_tb.sv =====
// Self-checking testbench for floor_cast_texel_shader: texel loads, floor shading, APB setup.
// Expected pixels come from an in-bench fixed-point floor caster; depends on fcts_pkg and the RTL.
module floor_cast_texel_shader_tb;

  localparam int PipeDrain = 100;
  localparam longint CellQ8 = fcts_pkg::SquareLen * 256;

  logic clk, rst, start, busy, strobe, psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  fcts_pkg::in_item_t in_item;
  fcts_pkg::out_item_t result;

  floor_cast_texel_shader dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .strobe(strobe), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic signed [15:0] sine_q15 [fcts_pkg::TrigEntries];
  logic [31:0] texels [fcts_pkg::StoreDepth];
  bit loaded [fcts_pkg::StoreDepth];
  fcts_pkg::out_item_t pixel_queue[$];
  int errors, n_shade, n_load, n_draw, n_results;

  logic [6:0] cfg_tex_w, cfg_tex_h;
  logic [11:0] cfg_scr_h;
  logic [23:0] cfg_ppd;
  logic signed [11:0] cfg_voff;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("floor_cast_texel_shader_tb: done, errors");
    $finish;
  end

  function automatic logic signed [15:0] taylor_sine(int k);
    longint unsigned ang, sq, t, acc, q;
    bit flip;
    ang = (longint'(k) * 64'd6746518852) / fcts_pkg::TrigEntries;
    flip = 0;
    if (ang >= 64'd3373259426) begin
      ang -= 64'd3373259426;
      flip = 1;
    end
    if (ang > 64'd1686629713) ang = 64'd3373259426 - ang;
    sq = (ang * ang) >> 30;
    t = ang;
    acc = ang;
    for (int n = 3; n <= 13; n += 2) begin
      t = ((t * sq) >> 30) / longint'((n - 1) * n);
      if (((n - 1) / 2) % 2 == 1) acc -= t;
      else acc += t;
    end
    q = (acc + 16384) >> 15;
    if (q > 32767) q = 32767;
    return flip ? -16'(q) : 16'(q);
  endfunction

  function automatic longint sin_of(logic [15:0] a);
    return longint'(sine_q15[a[15:6]]);
  endfunction

  function automatic longint q15_floor(longint s, longint d);
    longint p;
    p = s * d;
    if (p >= 0) return p / 32768;
    return -((-p + 32767) / 32768);
  endfunction

  function automatic longint cell_texel(longint pos, longint size);
    longint f;
    f = pos % CellQ8;
    if (f < 0) f += CellQ8;
    return (size * f) / CellQ8;
  endfunction

  // Floor point lookup; fetch is low when the row is at or above the horizon.
  function automatic void cast_floor(fcts_pkg::in_item_t it, output bit fetch,
                                     output int addr);
    longint horizon, r, straight, fdist, mag, cb, fx, fy, tc, tr;
    logic [15:0] beta;
    horizon = longint'(cfg_scr_h / 2) + longint'(cfg_voff);
    r = longint'(it.pixel_row) - horizon;
    fetch = r > 0;
    addr = 0;
    if (!fetch) return;
    beta = it.ray_angle - it.view_angle;
    straight = (longint'(fcts_pkg::SquareLen / 2) * longint'(cfg_ppd)) / r;
    if (straight > longint'(fcts_pkg::DistMax)) straight = longint'(fcts_pkg::DistMax);
    cb = sin_of(beta + 16'd16384);
    if (cb == 0) fdist = longint'(fcts_pkg::DistMax);
    else begin
      mag = cb < 0 ? -cb : cb;
      fdist = (straight * 32768) / mag;
      if (fdist > longint'(fcts_pkg::DistMax)) fdist = longint'(fcts_pkg::DistMax);
      if (cb < 0) fdist = -fdist;
    end
    fx = longint'(it.player_py) + q15_floor(sin_of(it.ray_angle), fdist);
    fy = longint'(it.player_px) + q15_floor(sin_of(it.ray_angle + 16'd16384), fdist);
    tc = cell_texel(fx, longint'(cfg_tex_w));
    tr = cell_texel(fy, longint'(cfg_tex_h));
    addr = int'((tr * fcts_pkg::TexDim + tc) % fcts_pkg::StoreDepth);
  endfunction

  task automatic random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return;
    start <= 0;
    if (p < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(10, 40)) @(posedge clk);
  endtask

  task automatic transfer(fcts_pkg::in_item_t it);
    bit fetch;
    int addr;
    fcts_pkg::out_item_t px;
    start <= 1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.action == fcts_pkg::ActLoad) begin
      texels[it.texel_addr] = it.texel_value;
      loaded[it.texel_addr] = 1;
      n_load++;
    end else begin
      cast_floor(it, fetch, addr);
      px.out_col = it.pixel_col;
      px.out_row = it.pixel_row;
      px.out_color = fetch ? texels[addr] : 32'd0;
      px.draw = px.out_color != 0;
      pixel_queue.push_back(px);
      n_shade++;
    end
    random_gap();
  endtask

  task automatic load_texel(int a, logic [31:0] v);
    fcts_pkg::in_item_t it;
    it = fcts_pkg::in_item_t'($urandom());
    it.action = fcts_pkg::ActLoad;
    it.texel_addr = a[11:0];
    it.texel_value = v;
    transfer(it);
  endtask

  // Shades one pixel, loading its texel first if the store has never seen it.
  task automatic shade(fcts_pkg::in_item_t it);
    bit fetch;
    int addr;
    it.action = fcts_pkg::ActShade;
    cast_floor(it, fetch, addr);
    if (fetch && !loaded[addr]) load_texel(addr, ($urandom_range(0, 7) == 0) ? 0 : $urandom());
    transfer(it);
  endtask

  function automatic fcts_pkg::in_item_t rand_pixel();
    fcts_pkg::in_item_t it;
    it = fcts_pkg::in_item_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom()});
    if ($urandom_range(0, 3) != 0)
      it.pixel_row = 12'(int'(cfg_scr_h / 2) + int'(cfg_voff) + int'($urandom_range(1, 300)));
    return it;
  endfunction

  task automatic drain();
    int guard;
    start <= 0;
    guard = 0;
    while (pixel_queue.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PipeDrain) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      fcts_pkg::RegTexWidth: cfg_tex_w = v[6:0];
      fcts_pkg::RegTexHeight: cfg_tex_h = v[6:0];
      fcts_pkg::RegScreenHeight: cfg_scr_h = v[11:0];
      fcts_pkg::RegProjPlaneDist: cfg_ppd = v[23:0];
      fcts_pkg::RegVerticalOffset: cfg_voff = v[11:0];
      default: ;
    endcase
  endtask

  task automatic setup(int tw, int th, int sh, int ppd, int voff);
    drain();
    apb_write(fcts_pkg::RegTexWidth, tw);
    apb_write(fcts_pkg::RegTexHeight, th);
    apb_write(fcts_pkg::RegScreenHeight, sh);
    apb_write(fcts_pkg::RegProjPlaneDist, ppd);
    apb_write(fcts_pkg::RegVerticalOffset, voff);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      n_results++;
      if (pixel_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual %h", $time, result);
      end else begin
        if (result.out_col !== pixel_queue[0].out_col)
          $display("%0t: out_col expected %h actual %h", $time, pixel_queue[0].out_col,
                   result.out_col);
        if (result.out_row !== pixel_queue[0].out_row)
          $display("%0t: out_row expected %h actual %h", $time, pixel_queue[0].out_row,
                   result.out_row);
        if (result.out_color !== pixel_queue[0].out_color)
          $display("%0t: out_color expected %h actual %h", $time, pixel_queue[0].out_color,
                   result.out_color);
        if (result.draw !== pixel_queue[0].draw)
          $display("%0t: draw expected %b actual %b", $time, pixel_queue[0].draw, result.draw);
        if (result !== pixel_queue[0]) errors++;
        if (result.draw === 1'b1) n_draw++;
        void'(pixel_queue.pop_front());
      end
    end
  end

  task automatic test_directed();
    fcts_pkg::in_item_t it;
    load_texel(0, 32'hFFFF_FFFF);
    load_texel(4095, 32'h0000_0001);
    load_texel(2080, 0);
    it = '0;
    it.pixel_row = 12'd512;
    shade(it);
    it.pixel_row = 12'd0;
    it.pixel_col = 12'hFFF;
    shade(it);
    it = '1;
    shade(it);
    it = '0;
    it.pixel_row = 12'd513;
    it.ray_angle = 16'd16384;
    shade(it);
    it.ray_angle = 16'd40000;
    it.view_angle = 16'd7232;
    it.pixel_row = 12'd700;
    shade(it);
    it.player_px = 24'hFFFFFF;
    it.player_py = 24'hFFFFFF;
    it.ray_angle = 16'hFFFF;
    it.view_angle = 16'h0000;
    shade(it);
    it.view_angle = 16'hFFFF;
    it.pixel_row = 12'hFFF;
    shade(it);
  endtask

  task automatic test_extreme_setups();
    setup(0, 0, 1, 0, 0);
    repeat (6) shade(rand_pixel());
    setup(127, 127, 4095, 24'hFFFFFF, -2048);
    repeat (12) shade(rand_pixel());
    setup(1, 64, 4095, 24'hFFFFFF, 2047);
    repeat (6) shade(rand_pixel());
  endtask

  task automatic test_random_mix();
    for (int ph = 0; ph < 6; ph++) begin
      setup($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(1, 4095),
            $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 4095));
      repeat (150) begin
        if ($urandom_range(0, 6) == 0) load_texel($urandom_range(0, 4095), $urandom());
        else shade(rand_pixel());
      end
    end
  endtask

  task automatic test_default_view();
    setup(64, 64, 1024, 221696, 0);
    repeat (130) shade(rand_pixel());
  endtask

  initial begin
    for (int k = 0; k < fcts_pkg::TrigEntries; k++) sine_q15[k] = taylor_sine(k);
    errors = 0;
    n_shade = 0;
    n_load = 0;
    n_draw = 0;
    n_results = 0;
    cfg_tex_w = 64;
    cfg_tex_h = 64;
    cfg_scr_h = 1024;
    cfg_ppd = 221696;
    cfg_voff = 0;
    rst = 1;
    start = 0;
    in_item = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_extreme_setups();
    test_random_mix();
    test_default_view();
    drain();
    $display("covered %0d shades, %0d loads, %0d pixels checked, %0d drawn",
             n_shade, n_load, n_results, n_draw);
    if (pixel_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d expected pixels never arrived", $time, pixel_queue.size());
    end
    if (errors == 0) $display("floor_cast_texel_shader_tb: done, clean");
    else $display("floor_cast_texel_shader_tb: done, errors");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/fcts_pkg.sv
rtl/core/fcts_ram.sv
rtl/core/fcts_front.sv
rtl/core/fcts_div.sv
rtl/core/fcts_back.sv
rtl/core/floor_cast_texel_shader.sv
tb/floor_cast_texel_shader_tb.sv
